// ===== src/heading_hold_strafe_controller_assert.svh =====
// assertion macros for the heading hold strafe controller
// a module that uses them has clk and rst_n in scope
`ifndef HEADING_HOLD_STRAFE_CONTROLLER_ASSERT_SVH
`define HEADING_HOLD_STRAFE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HHS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HHS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HHS_ASSERT(label, prop, msg)
`define HHS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== src/hhs_pkg.sv =====
`default_nettype none

package hhs_pkg;

    // field widths
    localparam int YAW_W      = 15;
    localparam int DIST_W     = 12;
    localparam int RANGE_W    = 10;
    localparam int GAIN_W     = 18;
    localparam int SPEED_W    = 9;
    localparam int LIMIT_W    = 17;
    localparam int THRESH_W   = 10;
    localparam int PULSE_W    = 11;
    localparam int INTEG_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // derived arithmetic widths
    localparam int DIFF_W   = YAW_W + 2;       // wide enough for the wrap adjustment
    localparam int DERIV_W  = YAW_W + 1;       // error minus previous error
    localparam int DERR_W   = DIST_W + 1;      // distance error
    localparam int PK_W     = GAIN_W + 1 + YAW_W;
    localparam int PI_W     = GAIN_W + 1 + INTEG_W;
    localparam int PD_W     = GAIN_W + 1 + DERIV_W;
    localparam int PU_W     = GAIN_W + 1 + DERR_W;
    localparam int ACC_W    = PI_W + 3;

    // angle and pulse constants
    localparam int YAW_FRAC  = 6;
    localparam int HALF_TURN = 11520;
    localparam int FULL_TURN = 23040;
    localparam logic [PULSE_W-1:0] NEUTRAL_US   = 11'd1500;
    localparam logic [PULSE_W-1:0] PULSE_MIN_US = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX_US = 11'd2000;

    // register reset values
    localparam logic [GAIN_W-1:0]   KP_HEADING_RST  = 18'd38400;
    localparam logic [GAIN_W-1:0]   KI_HEADING_RST  = 18'd192;
    localparam logic [GAIN_W-1:0]   KD_HEADING_RST  = 18'd0;
    localparam logic [GAIN_W-1:0]   KP_DISTANCE_RST = 18'd960;
    localparam logic [SPEED_W-1:0]  STRAFE_RST      = 9'd0;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST       = 17'd6400;
    localparam logic [THRESH_W-1:0] THRESH_RST      = 10'd60;

    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_HEADING  = 3'd0,
        CFG_KI_HEADING  = 3'd1,
        CFG_KD_HEADING  = 3'd2,
        CFG_KP_DISTANCE = 3'd3,
        CFG_STRAFE      = 3'd4,
        CFG_LIMIT       = 3'd5,
        CFG_THRESHOLD   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   kp_heading;
        logic [GAIN_W-1:0]   ki_heading;
        logic [GAIN_W-1:0]   kd_heading;
        logic [GAIN_W-1:0]   kp_distance;
        logic [SPEED_W-1:0]  strafe_speed;
        logic [LIMIT_W-1:0]  integral_limit;
        logic [THRESH_W-1:0] proximity_threshold;
    } cfg_t;

    typedef struct packed {
        logic                opcode;
        logic [YAW_W-1:0]    yaw;
        logic [DIST_W-1:0]   wall_distance;
        logic [RANGE_W-1:0]  left_range;
        logic [RANGE_W-1:0]  right_range;
    } item_t;

    typedef struct packed {
        logic            neutral;
        logic            stopped;
        logic [PK_W-1:0] pk;
        logic [PI_W-1:0] pi;
        logic [PD_W-1:0] pd;
        logic [PU_W-1:0] pu;
    } prod_t;

    typedef struct packed {
        logic [PULSE_W-1:0] front_left;
        logic [PULSE_W-1:0] rear_left;
        logic [PULSE_W-1:0] front_right;
        logic [PULSE_W-1:0] rear_right;
        logic               stopped;
    } result_t;

endpackage

`default_nettype wire

// ===== src/hhs_if.sv =====
`default_nettype none

interface hhs_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [hhs_pkg::YAW_W-1:0]    yaw;
    logic [hhs_pkg::DIST_W-1:0]   wall_distance;
    logic [hhs_pkg::RANGE_W-1:0]  left_range;
    logic [hhs_pkg::RANGE_W-1:0]  right_range;

    modport source (output valid, opcode, yaw, wall_distance, left_range, right_range,
                    input ready);
    modport sink (input valid, opcode, yaw, wall_distance, left_range, right_range,
                  output ready);
endinterface

interface hhs_pulse_if;
    logic                          valid;
    logic                          ready;
    logic [hhs_pkg::PULSE_W-1:0]   front_left_pulse;
    logic [hhs_pkg::PULSE_W-1:0]   rear_left_pulse;
    logic [hhs_pkg::PULSE_W-1:0]   front_right_pulse;
    logic [hhs_pkg::PULSE_W-1:0]   rear_right_pulse;
    logic                          stopped;

    modport source (output valid, front_left_pulse, rear_left_pulse, front_right_pulse,
                    rear_right_pulse, stopped, input ready);
    modport sink (input valid, front_left_pulse, rear_left_pulse, front_right_pulse,
                  rear_right_pulse, stopped, output ready);
endinterface

interface hhs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hhs_pkg::CFG_IDX_W-1:0]    index;
    logic [hhs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/heading_hold_strafe_controller.sv =====
// heading hold strafe controller with a mecanum mixer
//
// channels: samples takes one item per control tick (start or sample),
// pulses gives one result item per item taken, start items included (four pulse widths and
// the stop flag), cfg writes one gain/limit register per handshake
// (cfg.ready is always high, an unknown index is dropped)
//
// stages: an item taken passes through the three registered stages (input
// register, pid/multiply register, mixer result register) on its way to pulses;
// throughput is one item per cycle while pulses.ready stays high
//
// reset clears the references, integral, previous error, stop latch and all
// stage valid flags; registers return to their reset gains, speed, limit and threshold
//
// when the receiver stalls, results back up stage by stage; samples.ready
// only drops once all three stages hold an item
`default_nettype none

`include "heading_hold_strafe_controller_assert.svh"

module heading_hold_strafe_controller #(
    parameter int GAIN_FRAC_BITS = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    hhs_sample_if.sink   samples,
    hhs_pulse_if.source  pulses,
    hhs_cfg_if.sink      cfg
);
    import hhs_pkg::*;

    cfg_t     cfg_q;
    item_t    item_reg;
    prod_t    prod_q;
    result_t  res_q;

    logic item_valid_reg, item_valid_next;
    logic prod_valid_reg, prod_valid_next;
    logic out_valid_reg,  out_valid_next;

    logic out_free;
    logic prod_free;
    logic item_free;
    logic take_item;
    logic move_prod;
    logic move_out;

    // each stage frees up when empty or when the next one moves on
    assign out_free  = !out_valid_reg || pulses.ready;
    assign prod_free = !prod_valid_reg || out_free;
    assign item_free = !item_valid_reg || prod_free;

    assign take_item = samples.valid && item_free;
    assign move_prod = item_valid_reg && prod_free;
    assign move_out  = prod_valid_reg && out_free;

    assign samples.ready = item_free;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take_item)
            item_valid_next = 1'b1;
        else if (move_prod)
            item_valid_next = 1'b0;

        prod_valid_next = prod_valid_reg;
        if (move_prod)
            prod_valid_next = 1'b1;
        else if (move_out)
            prod_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (move_out)
            out_valid_next = 1'b1;
        else if (pulses.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_reg.opcode        <= samples.opcode;
            item_reg.yaw           <= samples.yaw;
            item_reg.wall_distance <= samples.wall_distance;
            item_reg.left_range    <= samples.left_range;
            item_reg.right_range   <= samples.right_range;
        end
    end

    hhs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg),
        .cfg   (cfg_q)
    );

    // state update and the four products
    hhs_pid_stage u_pid (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (move_prod),
        .item    (item_reg),
        .cfg     (cfg_q),
        .prod    (prod_q)
    );

    // mixing, rounding and saturation into the result register
    hhs_mix_stage #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mix (
        .clk          (clk),
        .load         (move_out),
        .prod         (prod_q),
        .strafe_speed (cfg_q.strafe_speed),
        .res          (res_q)
    );

    assign pulses.valid             = out_valid_reg;
    assign pulses.front_left_pulse  = res_q.front_left;
    assign pulses.rear_left_pulse   = res_q.rear_left;
    assign pulses.front_right_pulse = res_q.front_right;
    assign pulses.rear_right_pulse  = res_q.rear_right;
    assign pulses.stopped           = res_q.stopped;

    // input back-pressure only comes from a full, stalled pipeline
    `HHS_ASSERT(a_ready_only_drops_when_full, !samples.ready |-> (item_valid_reg && prod_valid_reg && pulses.valid && !pulses.ready), "samples stalled with room in the pipeline")

    // the front-left and rear-right pulse widths of every delivered result lie in the servo range
    `HHS_ASSERT(a_pulse_range, pulses.valid |-> (pulses.front_left_pulse >= PULSE_MIN_US && pulses.front_left_pulse <= PULSE_MAX_US && pulses.rear_right_pulse >= PULSE_MIN_US && pulses.rear_right_pulse <= PULSE_MAX_US), "pulse width out of range")

    // a stopped result always drives all motors to neutral
    `HHS_ASSERT_ALWAYS(a_stop_neutral, (pulses.valid && pulses.stopped) |-> (pulses.front_left_pulse == NEUTRAL_US && pulses.rear_left_pulse == NEUTRAL_US && pulses.front_right_pulse == NEUTRAL_US && pulses.rear_right_pulse == NEUTRAL_US), "stopped item with non-neutral pulses")

endmodule

`default_nettype wire

// ===== src/hhs_cfg_regs.sv =====
`default_nettype none

module hhs_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    hhs_cfg_if.sink       wr,
    output hhs_pkg::cfg_t cfg
);
    import hhs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign wr.ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr.valid)
        begin
            case (wr.index)
                CFG_KP_HEADING:  cfg_next.kp_heading  = wr.data;
                CFG_KI_HEADING:  cfg_next.ki_heading  = wr.data;
                CFG_KD_HEADING:  cfg_next.kd_heading  = wr.data;
                CFG_KP_DISTANCE: cfg_next.kp_distance = wr.data;
                CFG_STRAFE:      cfg_next.strafe_speed = wr.data[SPEED_W-1:0];
                CFG_LIMIT:       cfg_next.integral_limit = wr.data[LIMIT_W-1:0];
                CFG_THRESHOLD:   cfg_next.proximity_threshold = wr.data[THRESH_W-1:0];
                default:         cfg_next = cfg_reg;   // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_heading          <= KP_HEADING_RST;
            cfg_reg.ki_heading          <= KI_HEADING_RST;
            cfg_reg.kd_heading          <= KD_HEADING_RST;
            cfg_reg.kp_distance         <= KP_DISTANCE_RST;
            cfg_reg.strafe_speed        <= STRAFE_RST;
            cfg_reg.integral_limit      <= LIMIT_RST;
            cfg_reg.proximity_threshold <= THRESH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/hhs_pid_stage.sv =====
`default_nettype none

module hhs_pid_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  hhs_pkg::item_t item,
    input  hhs_pkg::cfg_t  cfg,
    output hhs_pkg::prod_t prod
);
    import hhs_pkg::*;

    localparam logic signed [DIFF_W-1:0] T1 = DIFF_W'(HALF_TURN);
    localparam logic signed [DIFF_W-1:0] F1 = DIFF_W'(FULL_TURN);

    logic signed [YAW_W-1:0]   ref_yaw_reg,  ref_yaw_next;
    logic        [DIST_W-1:0]  ref_dist_reg, ref_dist_next;
    logic signed [INTEG_W-1:0] integ_reg,    integ_next;
    logic signed [YAW_W-1:0]   prev_err_reg, prev_err_next;
    logic                      stop_reg,     stop_next;
    prod_t                     prod_reg,     prod_next;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  adj;
    logic signed [YAW_W-1:0]   err;
    logic signed [DERIV_W-1:0] derr;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W:0]   lim;
    logic signed [INTEG_W-1:0] integ_clamped;
    logic signed [DERR_W-1:0]  dist_err;
    logic                      too_close;

    // wrapped yaw error, the raw difference of two 15-bit angles stays
    // within one and a half turns, so one turn either way is enough
    assign diff = DIFF_W'(ref_yaw_reg) - DIFF_W'($signed(item.yaw));

    always_comb
    begin
        if (diff >= T1)
            adj = F1;
        else if (diff >= -T1)
            adj = '0;
        else
            adj = -F1;
    end

    assign err  = YAW_W'(diff - adj);
    assign derr = DERIV_W'(err) - DERIV_W'(prev_err_reg);

    // integral with symmetric clamp
    assign integ_sum = (INTEG_W + 1)'(integ_reg) + (INTEG_W + 1)'(err);
    assign lim       = $signed({2'b00, cfg.integral_limit});

    always_comb
    begin
        if (integ_sum > lim)
            integ_clamped = INTEG_W'(lim);
        else if (integ_sum < -lim)
            integ_clamped = INTEG_W'(-lim);
        else
            integ_clamped = INTEG_W'(integ_sum);
    end

    assign dist_err = DERR_W'($signed({1'b0, ref_dist_reg}))
                    - DERR_W'($signed({1'b0, item.wall_distance}));

    assign too_close = (item.left_range < cfg.proximity_threshold)
                    || (item.right_range < cfg.proximity_threshold);

    always_comb
    begin
        ref_yaw_next   = ref_yaw_reg;
        ref_dist_next  = ref_dist_reg;
        integ_next     = integ_reg;
        prev_err_next  = prev_err_reg;
        stop_next      = stop_reg;

        prod_next.neutral = 1'b1;
        prod_next.stopped = 1'b1;
        prod_next.pk = PK_W'($signed({1'b0, cfg.kp_heading})) * PK_W'(err);
        prod_next.pi = PI_W'($signed({1'b0, cfg.ki_heading})) * PI_W'(integ_clamped);
        prod_next.pd = PD_W'($signed({1'b0, cfg.kd_heading})) * PD_W'(derr);
        prod_next.pu = PU_W'($signed({1'b0, cfg.kp_distance})) * PU_W'(dist_err);

        if (item.opcode == OP_START)
        begin
            ref_yaw_next      = $signed(item.yaw);
            ref_dist_next     = item.wall_distance;
            stop_next         = 1'b0;
            prod_next.stopped = 1'b0;
        end
        else if (stop_reg)
        begin
            prod_next.stopped = 1'b1;
        end
        else if (too_close)
        begin
            stop_next         = 1'b1;
            prod_next.stopped = 1'b1;
        end
        else
        begin
            prev_err_next     = err;
            integ_next        = integ_clamped;
            prod_next.neutral = 1'b0;
            prod_next.stopped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_yaw_reg  <= '0;
            ref_dist_reg <= '0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            stop_reg     <= 1'b0;
        end
        else if (advance)
        begin
            ref_yaw_reg  <= ref_yaw_next;
            ref_dist_reg <= ref_dist_next;
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            stop_reg     <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== src/hhs_mix_stage.sv =====
`default_nettype none

module hhs_mix_stage #(
    parameter int GAIN_FRAC_BITS = 6
) (
    input  logic                           clk,
    input  logic                           load,
    input  hhs_pkg::prod_t                 prod,
    input  logic [hhs_pkg::SPEED_W-1:0]    strafe_speed,
    output hhs_pkg::result_t               res
);
    import hhs_pkg::*;

    localparam int SH = GAIN_FRAC_BITS + YAW_FRAC;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = $signed(ACC_W'(1) << (SH - 1));
    localparam logic signed [ACC_W-1:0] SAT_LO     = $signed(ACC_W'(PULSE_MIN_US));
    localparam logic signed [ACC_W-1:0] SAT_HI     = $signed(ACC_W'(PULSE_MAX_US));

    logic [PULSE_W:0]         spd_p;
    logic [PULSE_W:0]         spd_m;
    logic signed [ACC_W-1:0]  base_p;
    logic signed [ACC_W-1:0]  base_m;
    logic signed [ACC_W-1:0]  g;
    logic signed [ACC_W-1:0]  dd;
    result_t                  res_reg, res_next;

    // round to nearest us with ties upward, then saturate
    function automatic logic [PULSE_W-1:0] to_pulse(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] r;
        r = (x + ROUND_HALF) >>> SH;
        if (r < SAT_LO)
            to_pulse = PULSE_MIN_US;
        else if (r > SAT_HI)
            to_pulse = PULSE_MAX_US;
        else
            to_pulse = r[PULSE_W-1:0];
    endfunction

    assign spd_p  = (PULSE_W + 1)'(NEUTRAL_US) + (PULSE_W + 1)'(strafe_speed);
    assign spd_m  = (PULSE_W + 1)'(NEUTRAL_US) - (PULSE_W + 1)'(strafe_speed);
    assign base_p = $signed(ACC_W'(spd_p) << SH);
    assign base_m = $signed(ACC_W'(spd_m) << SH);

    assign g  = ACC_W'($signed(prod.pk)) + ACC_W'($signed(prod.pi))
              + ACC_W'($signed(prod.pd));
    assign dd = ACC_W'($signed(prod.pu)) <<< YAW_FRAC;

    always_comb
    begin
        res_next.stopped = prod.stopped;
        if (prod.neutral)
        begin
            res_next.front_left  = NEUTRAL_US;
            res_next.rear_left   = NEUTRAL_US;
            res_next.front_right = NEUTRAL_US;
            res_next.rear_right  = NEUTRAL_US;
        end
        else
        begin
            res_next.front_left  = to_pulse(base_p - g - dd);
            res_next.rear_left   = to_pulse(base_m - g - dd);
            res_next.front_right = to_pulse(base_m - g + dd);
            res_next.rear_right  = to_pulse(base_p - g + dd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire
